### sv/lat_pkg.sv
// Shared types and codes for the label address table.
package lat_pkg;

   localparam int TABLE_DEPTH_DEFAULT = 16;
   localparam int ENTRY_COUNT_W = 5;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_DELETE = 2'd1;
   localparam logic [1:0] OP_SEARCH = 2'd2;

   localparam logic [1:0] STATUS_DONE      = 2'd0;
   localparam logic [1:0] STATUS_EXISTS    = 2'd1;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;
   localparam logic [1:0] STATUS_FULL      = 2'd3;

   typedef struct packed {
      logic [1:0]  operation;
      logic [63:0] label_high;
      logic [63:0] label_mid;
      logic [23:0] label_low;
      logic [31:0] address;
   } req_type;

   typedef struct packed {
      logic [1:0]               status;
      logic [ENTRY_COUNT_W-1:0] entry_count;
   } rsp_type;

   typedef struct packed {
      logic [63:0] high;
      logic [63:0] mid;
      logic [23:0] low;
   } label_type;

   // lookup token flags carried down the chain
   typedef struct packed {
      logic active;
      logic hit;
      logic free_found;
   } probe_type;

   // broadcast table update
   typedef struct packed {
      logic wr_en;
      logic clr_en;
   } update_type;

endpackage

### sv/label_address_table.sv
// Label address table top level: request sequencing, entry count and response register.
// A new request is stalled until the current operation completes; its token walks
// the cell chain one cell per cycle; a stalled response holds back the next completion.
// Reset clears every valid mark, the entry count and the response valid at once;
// stored labels and addresses are not reset.
module label_address_table #(
   parameter int TABLE_DEPTH = lat_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  lat_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output lat_pkg::rsp_type rsp_payload
);

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   typedef enum logic [1:0] {IDLE, SCAN, FINISH} state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in, count_next;
   logic               rsp_valid_ff, rsp_valid_in;
   lat_pkg::rsp_type   rsp_ff, rsp_in;

   logic [1:0]         op_ff, op_in;
   logic               hit_ff, hit_in;
   logic               free_ff, free_in;
   logic [IDX_W-1:0]   hit_idx_ff, hit_idx_in;
   logic [IDX_W-1:0]   free_idx_ff, free_idx_in;
   lat_pkg::label_type label_ff, label_in;
   logic [31:0]        address_ff, address_in;

   logic               req_take;
   logic               finish_go;
   logic               do_write;
   logic               do_clear;
   logic [1:0]         status_sel;

   lat_pkg::label_type  head_key;
   lat_pkg::probe_type  head_probe;
   lat_pkg::update_type update;
   logic [IDX_W-1:0]    update_idx;
   lat_pkg::label_type  tail_key;
   lat_pkg::probe_type  tail_probe;
   logic [IDX_W-1:0]    tail_hit_idx;
   logic [IDX_W-1:0]    tail_free_idx;

   assign req_stall = (state_ff != IDLE);
   assign req_take  = req_valid && !req_stall;
   assign finish_go = (state_ff == FINISH) && (!rsp_valid_ff || !rsp_stall);

   assign head_key.high         = req_payload.label_high;
   assign head_key.mid          = req_payload.label_mid;
   assign head_key.low          = req_payload.label_low;
   assign head_probe.active     = req_take;
   assign head_probe.hit        = 1'b0;
   assign head_probe.free_found = 1'b0;

   always_comb begin
      do_write   = 1'b0;
      do_clear   = 1'b0;
      status_sel = lat_pkg::STATUS_DONE;
      unique case (op_ff)
         lat_pkg::OP_INSERT: begin
            priority if (hit_ff) begin
               status_sel = lat_pkg::STATUS_EXISTS;
            end else if (!free_ff) begin
               status_sel = lat_pkg::STATUS_FULL;
            end else begin
               do_write = 1'b1;
            end
         end
         lat_pkg::OP_DELETE: begin
            if (hit_ff) begin
               do_clear = 1'b1;
            end else begin
               status_sel = lat_pkg::STATUS_NOT_FOUND;
            end
         end
         lat_pkg::OP_SEARCH: begin
            status_sel = hit_ff ? lat_pkg::STATUS_DONE : lat_pkg::STATUS_NOT_FOUND;
         end
         default: begin
            status_sel = lat_pkg::STATUS_DONE;
         end
      endcase
   end

   always_comb begin
      count_next = count_ff;
      priority if (do_write) begin
         count_next = count_ff + CNT_W'(1);
      end else if (do_clear && (count_ff != '0)) begin
         count_next = count_ff - CNT_W'(1);
      end
   end

   assign update.wr_en = finish_go && do_write;
   assign update.clr_en = finish_go && do_clear;
   assign update_idx   = do_write ? free_idx_ff : hit_idx_ff;

   lat_chain #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .IDX_W       (IDX_W)
   ) u_chain (
      .clock          (clock),
      .reset          (reset),
      .head_key       (head_key),
      .head_probe     (head_probe),
      .update         (update),
      .update_idx     (update_idx),
      .update_label   (label_ff),
      .update_address (address_ff),
      .tail_key       (tail_key),
      .tail_probe     (tail_probe),
      .tail_hit_idx   (tail_hit_idx),
      .tail_free_idx  (tail_free_idx)
   );

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      op_in        = op_ff;
      address_in   = address_ff;
      hit_in       = hit_ff;
      free_in      = free_ff;
      hit_idx_in   = hit_idx_ff;
      free_idx_in  = free_idx_ff;
      label_in     = label_ff;
      unique case (state_ff)
         IDLE: begin
            if (req_take) begin
               op_in      = req_payload.operation;
               address_in = req_payload.address;
               state_in   = SCAN;
            end
         end
         SCAN: begin
            if (tail_probe.active) begin
               hit_in      = tail_probe.hit;
               free_in     = tail_probe.free_found;
               hit_idx_in  = tail_hit_idx;
               free_idx_in = tail_free_idx;
               label_in    = tail_key;
               state_in    = FINISH;
            end
         end
         FINISH: begin
            if (finish_go) begin
               count_in           = count_next;
               rsp_in.status      = status_sel;
               rsp_in.entry_count = lat_pkg::ENTRY_COUNT_W'(count_next);
               rsp_valid_in       = 1'b1;
               state_in           = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_ff       <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      address_ff  <= address_in;
      hit_ff      <= hit_in;
      free_ff     <= free_in;
      hit_idx_ff  <= hit_idx_in;
      free_idx_ff <= free_idx_in;
      label_ff    <= label_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("entry count above table depth");

   a_insert_counts: assert property (@(posedge clock) disable iff (reset)
      update.wr_en |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("insert did not increment entry count");

   a_token_in_scan: assert property (@(posedge clock) disable iff (reset)
      tail_probe.active |-> state_ff == SCAN)
      else $error("lookup token left chain outside scan");

   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      req_take |=> !rsp_valid_ff || $past(rsp_valid_ff))
      else $error("response raised the cycle after request transfer");

endmodule

### sv/lat_cell.sv
// One table entry with its stage of the lookup chain.
module lat_cell #(
   parameter int IDX_W      = 4,
   parameter int CELL_INDEX = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  lat_pkg::label_type     up_key,
   input  lat_pkg::probe_type     up_probe,
   input  logic [IDX_W-1:0]       up_hit_idx,
   input  logic [IDX_W-1:0]       up_free_idx,
   input  lat_pkg::update_type    update,
   input  logic [IDX_W-1:0]       update_idx,
   input  lat_pkg::label_type     update_label,
   input  logic [31:0]            update_address,
   output lat_pkg::label_type     dn_key,
   output lat_pkg::probe_type     dn_probe,
   output logic [IDX_W-1:0]       dn_hit_idx,
   output logic [IDX_W-1:0]       dn_free_idx
);

   localparam logic [IDX_W-1:0] MY_INDEX = IDX_W'(CELL_INDEX);

   logic                valid_ff, valid_in;
   lat_pkg::label_type  label_ff, label_in;
   logic [31:0]         address_ff, address_in;
   lat_pkg::label_type  key_ff;
   lat_pkg::probe_type  probe_ff, probe_in;
   logic [IDX_W-1:0]    hit_idx_ff, hit_idx_in;
   logic [IDX_W-1:0]    free_idx_ff, free_idx_in;
   logic                match;
   logic                selected;

   assign match    = valid_ff && (label_ff == up_key);
   assign selected = (update_idx == MY_INDEX);

   always_comb begin
      probe_in.active     = up_probe.active;
      probe_in.hit        = up_probe.hit | match;
      probe_in.free_found = up_probe.free_found | !valid_ff;
      hit_idx_in          = (!up_probe.hit && match) ? MY_INDEX : up_hit_idx;
      free_idx_in         = (!up_probe.free_found && !valid_ff) ? MY_INDEX : up_free_idx;
   end

   always_comb begin
      valid_in   = valid_ff;
      label_in   = label_ff;
      address_in = address_ff;
      priority if (update.wr_en && selected) begin
         valid_in   = 1'b1;
         label_in   = update_label;
         address_in = update_address;
      end else if (update.clr_en && selected) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         probe_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         probe_ff <= probe_in;
      end
   end

   always_ff @(posedge clock) begin
      label_ff    <= label_in;
      address_ff  <= address_in;
      key_ff      <= up_key;
      hit_idx_ff  <= hit_idx_in;
      free_idx_ff <= free_idx_in;
   end

   assign dn_key      = key_ff;
   assign dn_probe    = probe_ff;
   assign dn_hit_idx  = hit_idx_ff;
   assign dn_free_idx = free_idx_ff;

endmodule

### sv/lat_chain.sv
// Row of table cells through which each lookup token walks.
module lat_chain #(
   parameter int TABLE_DEPTH = lat_pkg::TABLE_DEPTH_DEFAULT,
   parameter int IDX_W       = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  lat_pkg::label_type  head_key,
   input  lat_pkg::probe_type  head_probe,
   input  lat_pkg::update_type update,
   input  logic [IDX_W-1:0]    update_idx,
   input  lat_pkg::label_type  update_label,
   input  logic [31:0]         update_address,
   output lat_pkg::label_type  tail_key,
   output lat_pkg::probe_type  tail_probe,
   output logic [IDX_W-1:0]    tail_hit_idx,
   output logic [IDX_W-1:0]    tail_free_idx
);

   lat_pkg::label_type key_link      [TABLE_DEPTH+1];
   lat_pkg::probe_type probe_link    [TABLE_DEPTH+1];
   logic [IDX_W-1:0]   hit_idx_link  [TABLE_DEPTH+1];
   logic [IDX_W-1:0]   free_idx_link [TABLE_DEPTH+1];

   assign key_link[0]      = head_key;
   assign probe_link[0]    = head_probe;
   assign hit_idx_link[0]  = '0;
   assign free_idx_link[0] = '0;

   for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      lat_cell #(
         .IDX_W      (IDX_W),
         .CELL_INDEX (g)
      ) u_cell (
         .clock          (clock),
         .reset          (reset),
         .up_key         (key_link[g]),
         .up_probe       (probe_link[g]),
         .up_hit_idx     (hit_idx_link[g]),
         .up_free_idx    (free_idx_link[g]),
         .update         (update),
         .update_idx     (update_idx),
         .update_label   (update_label),
         .update_address (update_address),
         .dn_key         (key_link[g+1]),
         .dn_probe       (probe_link[g+1]),
         .dn_hit_idx     (hit_idx_link[g+1]),
         .dn_free_idx    (free_idx_link[g+1])
      );
   end

   assign tail_key      = key_link[TABLE_DEPTH];
   assign tail_probe    = probe_link[TABLE_DEPTH];
   assign tail_hit_idx  = hit_idx_link[TABLE_DEPTH];
   assign tail_free_idx = free_idx_link[TABLE_DEPTH];

endmodule
